[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// Relies on a clk and an arst_n signal in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[rtl/tsjs_pkg.sv]
// Shared types and constants of the thread scheduler.
// No dependencies.
`default_nettype none

package tsjs_pkg;

	localparam int OP_W    = 3;
	localparam int TID_W   = 16;
	localparam int TIME_W  = 32;
	localparam int SEMIX_W = 2;
	localparam int SCNT_W  = 8;
	localparam int CNT_W   = 10;
	localparam int AWAIT_W = 17;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_YIELD  = 3'd1;
	localparam logic [OP_W-1:0] OP_JOIN   = 3'd2;
	localparam logic [OP_W-1:0] OP_WAIT   = 3'd3;
	localparam logic [OP_W-1:0] OP_SIGNAL = 3'd4;
	localparam logic [OP_W-1:0] OP_END    = 3'd5;
	localparam logic [OP_W-1:0] OP_INIT   = 3'd6;

	localparam logic [1:0] ST_READY   = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;
	localparam logic [1:0] ST_BLOCKED = 2'd2;

	localparam logic [AWAIT_W-1:0] AWAIT_NONE = 17'h10000;
	localparam logic signed [CNT_W-1:0] SEM_CNT_MAX = 10'sd511;

endpackage

`default_nettype wire

[rtl/tsjs_req_if.sv]
// Request channel of the thread scheduler: valid, ready and event fields.
// Depends on tsjs_pkg.
`default_nettype none

interface tsjs_req_if import tsjs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [TID_W-1:0]   target_tid;
	logic [TIME_W-1:0]  initial_priority;
	logic [TIME_W-1:0]  elapsed_time;
	logic [SEMIX_W-1:0] sem_index;
	logic [SCNT_W-1:0]  sem_start_count;

	modport source (output valid, op, target_tid, initial_priority, elapsed_time,
		sem_index, sem_start_count, input ready);
	modport sink (input valid, op, target_tid, initial_priority, elapsed_time,
		sem_index, sem_start_count, output ready);
endinterface

`default_nettype wire

[rtl/tsjs_rsp_if.sv]
// Response channel of the thread scheduler: valid, ready and result fields.
// Depends on tsjs_pkg.
`default_nettype none

interface tsjs_rsp_if import tsjs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             status;
	logic [TID_W-1:0] created_tid;
	logic             running_valid;
	logic [TID_W-1:0] running_tid;
	logic             switched;

	modport source (output valid, status, created_tid, running_valid, running_tid,
		switched, input ready);
	modport sink (input valid, status, created_tid, running_valid, running_tid,
		switched, output ready);
endinterface

`default_nettype wire

[rtl/tsjs_sat_add.sv]
// Saturating priority adder of the scheduler.
// Depends on tsjs_pkg.
`default_nettype none

module tsjs_sat_add import tsjs_pkg::*; #(
	parameter int PRIORITY_BITS = 32
) (
	input  logic [PRIORITY_BITS-1:0] base,
	input  logic [TIME_W-1:0]        delta,
	output logic [PRIORITY_BITS-1:0] sum
);
	localparam logic [64:0] LIMIT = {{(65-PRIORITY_BITS){1'b0}}, {PRIORITY_BITS{1'b1}}};

	logic [64:0] wide;

	always_comb begin
		wide = 65'(base) + 65'(delta);
		sum  = (wide > LIMIT) ? LIMIT[PRIORITY_BITS-1:0] : wide[PRIORITY_BITS-1:0];
	end
endmodule

`default_nettype wire

[rtl/thread_scheduler_join_semaphore.sv]
// Thread scheduler with join and counting semaphores, one request at a time.
// Slot scans, the sorted ready-list insert and the ready-list shift each walk
// one entry per cycle.
// Throughput: one request per response; ready is low until the response is taken.
// Reset: asynchronous, slot 0 running, all other slots free, lists empty.
`default_nettype none

module thread_scheduler_join_semaphore import tsjs_pkg::*; #(
	parameter int MAX_THREADS    = 16,
	parameter int NUM_SEMAPHORES = 4,
	parameter int PRIORITY_BITS  = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tsjs_req_if.sink    req,
	tsjs_rsp_if.source  rsp
);
	`include "assert_macros.svh"

	localparam int SW  = $clog2(MAX_THREADS);
	localparam int CW  = $clog2(MAX_THREADS + 1);
	localparam int SMW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int AW  = (NUM_SEMAPHORES * MAX_THREADS > 1) ?
		$clog2(NUM_SEMAPHORES * MAX_THREADS) : 1;
	localparam int PB  = PRIORITY_BITS;
	localparam logic [CW-1:0] FULL = CW'(MAX_THREADS);
	localparam logic [SW-1:0] LAST = SW'(MAX_THREADS - 1);

	typedef enum logic [11:0] {
		S_IDLE      = 12'b000000000001,
		S_FIND      = 12'b000000000010,
		S_SCAN_J    = 12'b000000000100,
		S_JOIN_FIN  = 12'b000000001000,
		S_SCAN_E    = 12'b000000010000,
		S_SIG_RD    = 12'b000000100000,
		S_SIG_CHK   = 12'b000001000000,
		S_INS_START = 12'b000010000000,
		S_INS_STEP  = 12'b000100000000,
		S_DISP      = 12'b001000000000,
		S_SHIFT     = 12'b010000000000,
		S_DONE      = 12'b100000000000
	} state_t;

	state_t state_q;

	logic                      used_q   [MAX_THREADS];
	logic [TID_W-1:0]          id_q     [MAX_THREADS];
	logic [PB-1:0]             prio_q   [MAX_THREADS];
	logic [1:0]                stat_q   [MAX_THREADS];
	logic [AWAIT_W-1:0]        awaits_q [MAX_THREADS];
	logic [SW-1:0]             order_q  [MAX_THREADS];
	logic [CW-1:0]             rlen_q;
	logic                      run_valid_q;
	logic [SW-1:0]             run_slot_q;
	logic [TID_W-1:0]          next_id_q;
	logic signed [CNT_W-1:0]   cnt_q    [NUM_SEMAPHORES];
	logic [SW-1:0]             shead_q  [NUM_SEMAPHORES];
	logic [CW-1:0]             slen_q   [NUM_SEMAPHORES];
	logic [SW-1:0]             wmem     [NUM_SEMAPHORES*MAX_THREADS];
	logic [SW-1:0]             wmem_rd_q;

	logic [TID_W-1:0]  target_q;
	logic [TIME_W-1:0] init_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [SMW-1:0]    sem_q;
	logic [TID_W-1:0]  gone_q;
	logic [CW-1:0]     idx_q;
	logic [SW-1:0]     ins_q;
	logic              ret_disp_q;
	logic              taken_q;
	logic              exists_q;
	logic              err_q;
	logic [TID_W-1:0]  created_q;
	logic              switched_q;

	logic              out_vld_q;
	logic              out_status_q;
	logic [TID_W-1:0]  out_created_q;
	logic              out_run_valid_q;
	logic [TID_W-1:0]  out_run_tid_q;
	logic              out_switched_q;

	logic              accept;
	logic              sem_ok;
	logic [SMW-1:0]    sem_sel;
	logic [SW-1:0]     idx;
	logic [SW-1:0]     idx_m1;
	logic [CW:0]       tail_sum;
	logic [SW-1:0]     tail;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [PB-1:0]     add_base;
	logic [TIME_W-1:0] add_delta;
	logic [PB-1:0]     add_sum;
	state_t            acc_state;
	logic              acc_err;

	assign req.ready = (state_q == S_IDLE) && !out_vld_q;
	assign accept    = req.valid && req.ready;
	assign sem_ok    = 32'(req.sem_index) < NUM_SEMAPHORES;
	assign sem_sel   = (state_q == S_IDLE) ? SMW'(req.sem_index) : sem_q;
	assign idx       = idx_q[SW-1:0];
	assign idx_m1    = SW'(idx_q - CW'(1));

	// tail of the circular wait list of the selected semaphore
	always_comb begin
		tail_sum = (CW+1)'(shead_q[sem_sel]) + (CW+1)'(slen_q[sem_sel]);
		if (tail_sum >= (CW+1)'(MAX_THREADS))
			tail_sum = tail_sum - (CW+1)'(MAX_THREADS);
		tail    = tail_sum[SW-1:0];
		wr_addr = AW'(32'(sem_sel) * MAX_THREADS + 32'(tail));
		rd_addr = AW'(32'(sem_q) * MAX_THREADS + 32'(shead_q[sem_q]));
	end

	assign wr_en = accept && req.op == OP_WAIT && sem_ok && !(cnt_q[sem_sel] > 0)
		&& run_valid_q && slen_q[sem_sel] < FULL;

	always_ff @(posedge clk) begin
		if (wr_en)
			wmem[wr_addr] <= run_slot_q;
		wmem_rd_q <= wmem[rd_addr];
	end

	always_comb begin
		add_base  = (state_q == S_FIND) ? '0 : prio_q[run_slot_q];
		case (state_q)
			S_IDLE:  add_delta = req.elapsed_time;
			S_FIND:  add_delta = init_q;
			default: add_delta = elapsed_q;
		endcase
	end

	// first step and error of the incoming request
	always_comb begin
		acc_err   = 1'b0;
		acc_state = S_DONE;
		case (req.op)
			OP_CREATE: acc_state = S_FIND;
			OP_YIELD: begin
				if (!run_valid_q)
					acc_err = 1'b1;
				else
					acc_state = S_INS_START;
			end
			OP_JOIN: begin
				if (!run_valid_q || id_q[run_slot_q] == req.target_tid)
					acc_err = 1'b1;
				else
					acc_state = S_SCAN_J;
			end
			OP_WAIT: begin
				if (!sem_ok)
					acc_err = 1'b1;
				else if (cnt_q[sem_sel] > 0)
					acc_state = S_DONE;
				else if (!run_valid_q)
					acc_err = 1'b1;
				else
					acc_state = S_DISP;
			end
			OP_SIGNAL: begin
				if (!sem_ok)
					acc_err = 1'b1;
				else if (slen_q[sem_sel] != '0)
					acc_state = S_SIG_RD;
			end
			OP_END: begin
				if (!run_valid_q)
					acc_err = 1'b1;
				else
					acc_state = S_SCAN_E;
			end
			OP_INIT: begin
				if (!sem_ok)
					acc_err = 1'b1;
			end
			default: acc_err = 1'b1;
		endcase
	end

	tsjs_sat_add #(.PRIORITY_BITS(PB)) u_add (
		.base  (add_base),
		.delta (add_delta),
		.sum   (add_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < MAX_THREADS; i++) begin
				used_q[i]   <= (i == 0);
				id_q[i]     <= '0;
				prio_q[i]   <= '0;
				stat_q[i]   <= (i == 0) ? ST_RUNNING : ST_READY;
				awaits_q[i] <= AWAIT_NONE;
			end
			for (int s = 0; s < NUM_SEMAPHORES; s++) begin
				cnt_q[s]   <= '0;
				shead_q[s] <= '0;
				slen_q[s]  <= '0;
			end
			rlen_q      <= '0;
			run_valid_q <= 1'b1;
			run_slot_q  <= '0;
			next_id_q   <= TID_W'(1);
			out_vld_q   <= 1'b0;
			idx_q       <= '0;
			ret_disp_q  <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready)
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						target_q   <= req.target_tid;
						init_q     <= req.initial_priority;
						elapsed_q  <= req.elapsed_time;
						sem_q      <= sem_sel;
						err_q      <= acc_err;
						created_q  <= '0;
						switched_q <= 1'b0;
						taken_q    <= 1'b0;
						exists_q   <= 1'b0;
						idx_q      <= '0;
						state_q    <= acc_state;
						case (req.op)
							OP_YIELD: begin
								if (run_valid_q) begin
									prio_q[run_slot_q] <= add_sum;
									ins_q      <= run_slot_q;
									ret_disp_q <= 1'b1;
								end
							end
							OP_WAIT: begin
								if (sem_ok) begin
									if (cnt_q[sem_sel] > 0) begin
										cnt_q[sem_sel] <= cnt_q[sem_sel] - CNT_W'(1);
									end else if (run_valid_q) begin
										prio_q[run_slot_q] <= add_sum;
										stat_q[run_slot_q] <= ST_BLOCKED;
										if (slen_q[sem_sel] < FULL)
											slen_q[sem_sel] <= slen_q[sem_sel] + CW'(1);
										cnt_q[sem_sel] <= cnt_q[sem_sel] - CNT_W'(1);
									end
								end
							end
							OP_SIGNAL: begin
								if (sem_ok && cnt_q[sem_sel] < SEM_CNT_MAX)
									cnt_q[sem_sel] <= cnt_q[sem_sel] + CNT_W'(1);
							end
							OP_END: begin
								if (run_valid_q) begin
									gone_q               <= id_q[run_slot_q];
									used_q[run_slot_q]   <= 1'b0;
									stat_q[run_slot_q]   <= ST_READY;
									awaits_q[run_slot_q] <= AWAIT_NONE;
									prio_q[run_slot_q]   <= '0;
								end
							end
							OP_INIT: begin
								if (sem_ok) begin
									cnt_q[sem_sel]  <= CNT_W'(req.sem_start_count);
									slen_q[sem_sel] <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				S_FIND: begin
					if (!used_q[idx]) begin
						used_q[idx]   <= 1'b1;
						id_q[idx]     <= next_id_q;
						prio_q[idx]   <= add_sum;
						awaits_q[idx] <= AWAIT_NONE;
						created_q     <= next_id_q;
						next_id_q     <= next_id_q + TID_W'(1);
						ins_q         <= idx;
						ret_disp_q    <= 1'b0;
						state_q       <= S_INS_START;
					end else if (idx == LAST) begin
						err_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SCAN_J: begin
					if (used_q[idx] && idx != run_slot_q) begin
						if (stat_q[idx] == ST_BLOCKED && awaits_q[idx] == AWAIT_W'(target_q))
							taken_q <= 1'b1;
						if (id_q[idx] == target_q &&
						    (stat_q[idx] == ST_READY || stat_q[idx] == ST_BLOCKED))
							exists_q <= 1'b1;
					end
					if (idx == LAST)
						state_q <= S_JOIN_FIN;
					else
						idx_q <= idx_q + CW'(1);
				end
				S_JOIN_FIN: begin
					if (taken_q || !exists_q) begin
						err_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						prio_q[run_slot_q]   <= add_sum;
						awaits_q[run_slot_q] <= AWAIT_W'(target_q);
						stat_q[run_slot_q]   <= ST_BLOCKED;
						state_q              <= S_DISP;
					end
				end
				S_SCAN_E: begin
					// wake only the first blocked joiner of the ended thread
					if (used_q[idx] && stat_q[idx] == ST_BLOCKED &&
					    awaits_q[idx] == AWAIT_W'(gone_q)) begin
						awaits_q[idx] <= AWAIT_NONE;
						ins_q         <= idx;
						ret_disp_q    <= 1'b1;
						state_q       <= S_INS_START;
					end else if (idx == LAST) begin
						state_q <= S_DISP;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SIG_RD: begin
					// pop the wait list head; data arrives next cycle
					shead_q[sem_q] <= (shead_q[sem_q] == LAST) ? '0 : shead_q[sem_q] + SW'(1);
					slen_q[sem_q]  <= slen_q[sem_q] - CW'(1);
					state_q        <= S_SIG_CHK;
				end
				S_SIG_CHK: begin
					if (used_q[wmem_rd_q] && stat_q[wmem_rd_q] == ST_BLOCKED) begin
						ins_q      <= wmem_rd_q;
						ret_disp_q <= 1'b0;
						state_q    <= S_INS_START;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_INS_START: begin
					if (rlen_q == FULL) begin
						state_q <= ret_disp_q ? S_DISP : S_DONE;
					end else begin
						idx_q   <= rlen_q;
						state_q <= S_INS_STEP;
					end
				end
				S_INS_STEP: begin
					// walk from the tail; equal priorities stay ahead
					if (idx_q != '0 && prio_q[order_q[idx_m1]] > prio_q[ins_q]) begin
						order_q[idx] <= order_q[idx_m1];
						idx_q        <= idx_q - CW'(1);
					end else begin
						order_q[idx]  <= ins_q;
						rlen_q        <= rlen_q + CW'(1);
						stat_q[ins_q] <= ST_READY;
						state_q       <= ret_disp_q ? S_DISP : S_DONE;
					end
				end
				S_DISP: begin
					if (rlen_q == '0) begin
						run_valid_q <= 1'b0;
						state_q     <= S_DONE;
					end else begin
						run_slot_q          <= order_q[0];
						run_valid_q         <= 1'b1;
						stat_q[order_q[0]]  <= ST_RUNNING;
						switched_q          <= 1'b1;
						rlen_q              <= rlen_q - CW'(1);
						idx_q               <= CW'(1);
						state_q             <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (idx_q <= rlen_q) begin
						order_q[idx_m1] <= order_q[idx];
						idx_q           <= idx_q + CW'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					out_vld_q       <= 1'b1;
					out_status_q    <= err_q;
					out_created_q   <= created_q;
					out_run_valid_q <= run_valid_q;
					out_run_tid_q   <= run_valid_q ? id_q[run_slot_q] : '0;
					out_switched_q  <= switched_q;
					state_q         <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_status_q;
	assign rsp.created_tid   = out_created_q;
	assign rsp.running_valid = out_run_valid_q;
	assign rsp.running_tid   = out_run_tid_q;
	assign rsp.switched      = out_switched_q;

	`ASSERT_NEVER(a_rlen_range, rlen_q > FULL, "ready list longer than thread table")
	`ASSERT_CLK(a_run_slot_live,
		(state_q == S_IDLE && run_valid_q) |->
		(used_q[run_slot_q] && stat_q[run_slot_q] == ST_RUNNING),
		"running slot not live and running while idle")
	`ASSERT_CLK(a_accept_busy, accept |=> state_q != S_IDLE,
		"request accepted but sequencer stayed idle")
	`ASSERT_CLK(a_done_to_rsp, state_q == S_DONE |=> out_vld_q,
		"sequencer finished without a response")

endmodule

`default_nettype wire
